/* hdl/pcsc_pkg.sv */
// Shared types, codes and helper functions for the PNG chunk stream checker.
// Depends on nothing; the parser, the result queue and the top level refer to it by scoped names.
package pcsc_pkg;

    // Depth of the result queue and the width of its pointers.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // Chunk type words, big-endian as they appear in the file.
    localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
    localparam logic [31:0] TYPE_ZTXT = 32'h7a54_5874;
    localparam logic [31:0] TYPE_TIME = 32'h7449_4d45;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4e44;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC,
        PH_TRAIL
    } phase_t;

    typedef enum logic [1:0] {
        REC_TEXT,
        REC_CHUNK,
        REC_FILE
    } rec_kind_t;

    typedef enum logic [2:0] {
        KIND_TEXT,
        KIND_ZTXT,
        KIND_TIME,
        KIND_IEND,
        KIND_OTHER
    } chunk_kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_SIG,
        ST_CRC,
        ST_NO_NUL,
        ST_BAD_TIME,
        ST_TRUNC,
        ST_BAD_IEND
    } status_t;

    // One result record as it leaves the block.
    typedef struct packed {
        rec_kind_t   record_kind;
        chunk_kind_t chunk_kind;
        logic [7:0]  text_byte;
        logic        separator_mark;
        status_t     status;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } rec_t;

    // Up to two records pushed into the queue per input transfer; the second
    // slot is only used when the first one is.
    typedef struct packed {
        logic valid0;
        logic valid1;
        rec_t rec0;
        rec_t rec1;
    } push_t;

    // The eight bytes of the PNG signature.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h89;
            3'd1:    val = 8'h50;
            3'd2:    val = 8'h4e;
            3'd3:    val = 8'h47;
            3'd4:    val = 8'h0d;
            3'd5:    val = 8'h0a;
            3'd6:    val = 8'h1a;
            default: val = 8'h0a;
        endcase
        return val;
    endfunction

    // Byte-wide update of the reflected CRC-32.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic chunk_kind_t classify(input logic [31:0] t);
        chunk_kind_t k;
        priority if (t == TYPE_TEXT) k = KIND_TEXT;
        else if (t == TYPE_ZTXT)     k = KIND_ZTXT;
        else if (t == TYPE_TIME)     k = KIND_TIME;
        else if (t == TYPE_IEND)     k = KIND_IEND;
        else                         k = KIND_OTHER;
        return k;
    endfunction

endpackage

/* hdl/pcsc_file_if.sv */
// Input channel of the checker: one file byte per transfer with an end-of-file flag.
// Standalone; no package dependency.
interface pcsc_file_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, data_byte, end_of_file, input ready);
    modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

/* hdl/pcsc_record_if.sv */
// Output channel of the checker: one text record, chunk verdict or file verdict per transfer.
// Standalone; no package dependency.
interface pcsc_record_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [2:0]  chunk_kind;
    logic [7:0]  text_byte;
    logic        separator_mark;
    logic [2:0]  status;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;

    modport source (output valid, record_kind, chunk_kind, text_byte, separator_mark, status,
                    year, month, day, hour, minute, second, input ready);
    modport sink   (input valid, record_kind, chunk_kind, text_byte, separator_mark, status,
                    year, month, day, hour, minute, second, output ready);
endinterface

/* hdl/pcsc_parser.sv */
// Byte-at-a-time PNG parser: signature check, chunk splitting, CRC-32 and record generation.
// Depends on pcsc_pkg.
module pcsc_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     data_byte,
    input  logic           end_of_file,
    output pcsc_pkg::push_t push
);

    pcsc_pkg::phase_t    phase_reg, phase_next, phase_step;
    pcsc_pkg::status_t   err_reg, err_next, err_step;
    logic [30:0]         count_reg, count_next, count_step;
    logic [30:0]         len_reg, len_next;
    logic [31:0]         ctype_reg, ctype_next;
    logic [31:0]         crc_reg, crc_next;
    logic [31:0]         rcrc_reg, rcrc_next;
    logic                time_seen_reg, time_seen_next;
    logic                nul_seen_reg, nul_seen_next;
    logic                prev_nul_reg, prev_nul_next;
    logic                pair_seen_reg, pair_seen_next;
    logic [7:0]          time_bytes_reg [7];

    pcsc_pkg::chunk_kind_t kind;
    pcsc_pkg::status_t     chunk_status;
    pcsc_pkg::status_t     file_status;
    logic [31:0]           crc_upd;
    logic [31:0]           len_full;
    logic [31:0]           rcrc_full;
    logic [30:0]           count_inc;
    logic                  is_nul;
    logic                  consume;
    logic                  file_end;
    logic                  time_we;
    logic                  text_fire;
    logic                  verdict_fire;
    pcsc_pkg::rec_t        rec_text;
    pcsc_pkg::rec_t        rec_verdict;
    pcsc_pkg::rec_t        rec_file;

    // Shared decode of the current byte and the chunk gathered so far.
    assign kind      = pcsc_pkg::classify(ctype_reg);
    assign crc_upd   = pcsc_pkg::crc32_byte(crc_reg, data_byte);
    assign len_full  = {len_reg[23:0], data_byte};
    assign rcrc_full = {rcrc_reg[23:0], data_byte};
    assign count_inc = count_reg + 31'd1;
    assign is_nul    = (data_byte == 8'h00);
    assign consume   = accept && (err_reg == pcsc_pkg::ST_OK);
    assign file_end  = accept && end_of_file;
    assign time_we   = consume && (phase_reg == pcsc_pkg::PH_DATA)
                       && (kind == pcsc_pkg::KIND_TIME) && (count_reg < 31'd7);

    // Chunk checks, highest precedence first.
    always_comb
    begin
        priority if ((kind == pcsc_pkg::KIND_TIME) && (time_seen_reg || (len_reg != 31'd7)))
            chunk_status = pcsc_pkg::ST_BAD_TIME;
        else if (~crc_reg != rcrc_full)
            chunk_status = pcsc_pkg::ST_CRC;
        else if ((kind == pcsc_pkg::KIND_TEXT) && !nul_seen_reg)
            chunk_status = pcsc_pkg::ST_NO_NUL;
        else if ((kind == pcsc_pkg::KIND_ZTXT) && !pair_seen_reg)
            chunk_status = pcsc_pkg::ST_NO_NUL;
        else if ((kind == pcsc_pkg::KIND_IEND) && (len_reg != 31'd0))
            chunk_status = pcsc_pkg::ST_BAD_IEND;
        else
            chunk_status = pcsc_pkg::ST_OK;
    end

    // Next state: the effect of the byte, then the return to reset values at end of file.
    always_comb
    begin
        phase_step     = phase_reg;
        err_step       = err_reg;
        count_step     = count_reg;
        len_next       = len_reg;
        ctype_next     = ctype_reg;
        crc_next       = crc_reg;
        rcrc_next      = rcrc_reg;
        time_seen_next = time_seen_reg;
        nul_seen_next  = nul_seen_reg;
        prev_nul_next  = prev_nul_reg;
        pair_seen_next = pair_seen_reg;

        if (consume)
        begin
            unique case (phase_reg)
                pcsc_pkg::PH_SIG:
                begin
                    if (data_byte != pcsc_pkg::sig_byte(count_reg[2:0]))
                    begin
                        err_step = pcsc_pkg::ST_BAD_SIG;
                    end
                    else if (count_inc == 31'd8)
                    begin
                        phase_step     = pcsc_pkg::PH_LEN;
                        count_step     = '0;
                        len_next       = '0;
                        ctype_next     = '0;
                        crc_next       = pcsc_pkg::CRC_PRESET;
                        rcrc_next      = '0;
                        nul_seen_next  = 1'b0;
                        prev_nul_next  = 1'b0;
                        pair_seen_next = 1'b0;
                    end
                    else
                    begin
                        count_step = count_inc;
                    end
                end
                pcsc_pkg::PH_LEN:
                begin
                    len_next   = len_full[30:0];
                    count_step = count_inc;
                    if (count_inc == 31'd4)
                    begin
                        if (len_full[31])
                        begin
                            err_step = pcsc_pkg::ST_TRUNC;
                        end
                        else
                        begin
                            phase_step = pcsc_pkg::PH_TYPE;
                            count_step = '0;
                        end
                    end
                end
                pcsc_pkg::PH_TYPE:
                begin
                    crc_next   = crc_upd;
                    ctype_next = {ctype_reg[23:0], data_byte};
                    count_step = count_inc;
                    if (count_inc == 31'd4)
                    begin
                        phase_step = (len_reg != 31'd0) ? pcsc_pkg::PH_DATA : pcsc_pkg::PH_CRC;
                        count_step = '0;
                    end
                end
                pcsc_pkg::PH_DATA:
                begin
                    crc_next      = crc_upd;
                    prev_nul_next = is_nul;
                    if (is_nul && prev_nul_reg)
                    begin
                        pair_seen_next = 1'b1;
                    end
                    if (is_nul)
                    begin
                        nul_seen_next = 1'b1;
                    end
                    count_step = count_inc;
                    if (count_inc >= len_reg)
                    begin
                        phase_step = pcsc_pkg::PH_CRC;
                        count_step = '0;
                    end
                end
                pcsc_pkg::PH_CRC:
                begin
                    rcrc_next  = rcrc_full;
                    count_step = count_inc;
                    if (count_inc == 31'd4)
                    begin
                        if (chunk_status != pcsc_pkg::ST_OK)
                        begin
                            err_step = chunk_status;
                        end
                        else
                        begin
                            if (kind == pcsc_pkg::KIND_TIME)
                            begin
                                time_seen_next = 1'b1;
                            end
                            phase_step     = (kind == pcsc_pkg::KIND_IEND) ? pcsc_pkg::PH_TRAIL
                                                                           : pcsc_pkg::PH_LEN;
                            count_step     = '0;
                            len_next       = '0;
                            ctype_next     = '0;
                            crc_next       = pcsc_pkg::CRC_PRESET;
                            rcrc_next      = '0;
                            nul_seen_next  = 1'b0;
                            prev_nul_next  = 1'b0;
                            pair_seen_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // Any byte after a good IEND.
                    err_step = pcsc_pkg::ST_BAD_IEND;
                end
            endcase
        end

        // A file verdict returns everything to the reset values.
        if (file_end)
        begin
            len_next       = '0;
            ctype_next     = '0;
            crc_next       = pcsc_pkg::CRC_PRESET;
            rcrc_next      = '0;
            time_seen_next = 1'b0;
            nul_seen_next  = 1'b0;
            prev_nul_next  = 1'b0;
            pair_seen_next = 1'b0;
        end
    end

    assign phase_next = file_end ? pcsc_pkg::PH_SIG : phase_step;
    assign err_next   = file_end ? pcsc_pkg::ST_OK  : err_step;
    assign count_next = file_end ? 31'd0            : count_step;

    // Verdict for the whole file, taken from the state left by the final byte.
    always_comb
    begin
        priority if (err_step != pcsc_pkg::ST_OK)
            file_status = err_step;
        else if (phase_step == pcsc_pkg::PH_TRAIL)
            file_status = pcsc_pkg::ST_OK;
        else if ((phase_step == pcsc_pkg::PH_LEN) && (count_step == 31'd0))
            file_status = pcsc_pkg::ST_BAD_IEND;
        else
            file_status = pcsc_pkg::ST_TRUNC;
    end

    // Outputs: the records that this transfer produces.
    always_comb
    begin
        text_fire    = consume && (phase_reg == pcsc_pkg::PH_DATA)
                       && ((kind == pcsc_pkg::KIND_TEXT)
                           || ((kind == pcsc_pkg::KIND_ZTXT) && !nul_seen_reg));
        verdict_fire = consume && (phase_reg == pcsc_pkg::PH_CRC) && (count_inc == 31'd4);

        rec_text                = '0;
        rec_text.record_kind    = pcsc_pkg::REC_TEXT;
        rec_text.chunk_kind     = kind;
        rec_text.text_byte      = data_byte;
        rec_text.separator_mark = is_nul && !nul_seen_reg;
        rec_text.status         = pcsc_pkg::ST_OK;

        rec_verdict             = '0;
        rec_verdict.record_kind = pcsc_pkg::REC_CHUNK;
        rec_verdict.chunk_kind  = kind;
        rec_verdict.status      = chunk_status;
        if ((kind == pcsc_pkg::KIND_TIME) && (chunk_status == pcsc_pkg::ST_OK))
        begin
            rec_verdict.year   = {time_bytes_reg[0], time_bytes_reg[1]};
            rec_verdict.month  = time_bytes_reg[2];
            rec_verdict.day    = time_bytes_reg[3];
            rec_verdict.hour   = time_bytes_reg[4];
            rec_verdict.minute = time_bytes_reg[5];
            rec_verdict.second = time_bytes_reg[6];
        end

        rec_file             = '0;
        rec_file.record_kind = pcsc_pkg::REC_FILE;
        rec_file.chunk_kind  = pcsc_pkg::KIND_IEND;
        rec_file.status      = file_status;

        push.valid0 = text_fire || verdict_fire || file_end;
        push.valid1 = (text_fire || verdict_fire) && file_end;
        push.rec0   = text_fire ? rec_text : (verdict_fire ? rec_verdict : rec_file);
        push.rec1   = rec_file;
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pcsc_pkg::PH_SIG;
            err_reg       <= pcsc_pkg::ST_OK;
            count_reg     <= '0;
            len_reg       <= '0;
            ctype_reg     <= '0;
            crc_reg       <= pcsc_pkg::CRC_PRESET;
            rcrc_reg      <= '0;
            time_seen_reg <= 1'b0;
            nul_seen_reg  <= 1'b0;
            prev_nul_reg  <= 1'b0;
            pair_seen_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            ctype_reg     <= ctype_next;
            crc_reg       <= crc_next;
            rcrc_reg      <= rcrc_next;
            time_seen_reg <= time_seen_next;
            nul_seen_reg  <= nul_seen_next;
            prev_nul_reg  <= prev_nul_next;
            pair_seen_reg <= pair_seen_next;
        end
    end

    // tIME payload bytes; only read once all seven have been written in the chunk.
    always_ff @(posedge clk)
    begin
        if (time_we)
        begin
            time_bytes_reg[count_reg[2:0]] <= data_byte;
        end
    end

    // A file verdict always leaves the parser at the start of a new file.
    assert property (@(posedge clk) disable iff (!rst_n)
        file_end |=> (phase_reg == pcsc_pkg::PH_SIG) && (err_reg == pcsc_pkg::ST_OK)
                     && (count_reg == 31'd0))
        else $error("parser not back at file start after file verdict");

    // A latched error holds until the end of the file.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((err_reg != pcsc_pkg::ST_OK) && !file_end) |=> (err_reg == $past(err_reg)))
        else $error("latched error changed before end of file");

    // The second record of a transfer is always the file verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> (push.rec1.record_kind == pcsc_pkg::REC_FILE) && file_end)
        else $error("second record is not a file verdict");

endmodule

/* hdl/pcsc_result_fifo.sv */
// Small result queue taking up to two records per cycle and giving out one.
// Depends on pcsc_pkg.
module pcsc_result_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  pcsc_pkg::push_t push,
    output logic            space_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output pcsc_pkg::rec_t  out_rec
);

    pcsc_pkg::rec_t                 mem [pcsc_pkg::FIFO_DEPTH];
    logic [pcsc_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [pcsc_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [pcsc_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [pcsc_pkg::PTR_W-1:0]     wr_ptr_inc;
    logic                           pop;

    // Room for two records is required before an input transfer is allowed.
    assign space_ok   = (count_reg <= pcsc_pkg::CNT_W'(pcsc_pkg::FIFO_DEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign out_rec    = mem[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + pcsc_pkg::PTR_W'(1);

    // Pointer and fill-level arithmetic.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + pcsc_pkg::PTR_W'(push.valid0) + pcsc_pkg::PTR_W'(push.valid1);
        rd_ptr_next = rd_ptr_reg + pcsc_pkg::PTR_W'(pop);
        count_next  = count_reg + pcsc_pkg::CNT_W'(push.valid0)
                      + pcsc_pkg::CNT_W'(push.valid1) - pcsc_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            mem[wr_ptr_reg] <= push.rec0;
        end
        if (push.valid1)
        begin
            mem[wr_ptr_inc] <= push.rec1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pcsc_pkg::CNT_W'(pcsc_pkg::FIFO_DEPTH))
        else $error("result queue fill level out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> push.valid0)
        else $error("second push slot used without the first");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid0 |-> space_ok)
        else $error("push into result queue without room for two records");

endmodule

/* hdl/png_chunk_stream_checker_core.sv */
// PNG chunk stream checker, top level: parser followed by a four-record result queue.
// Each record is queued by the byte transfer that causes it, behind any records not yet taken.
// Throughput: one file byte per cycle; input ready falls while the result queue holds more
// than two records, which takes output stalls or end-of-file bytes close together.
// Reset (rst_n low, asynchronous): parse state, latched error and queue pointers are cleared.
// Depends on pcsc_pkg, pcsc_file_if, pcsc_record_if, pcsc_parser and pcsc_result_fifo.
module png_chunk_stream_checker_core (
    input  logic           clk,
    input  logic           rst_n,
    pcsc_file_if.sink      file_stream,
    pcsc_record_if.source  record_stream
);

    pcsc_pkg::push_t push;
    pcsc_pkg::rec_t  head_rec;
    logic            space_ok;
    logic            accept;

    assign file_stream.ready = space_ok;
    assign accept            = file_stream.valid && space_ok;

    // Byte parser: updates the chunk state and builds records on each input transfer.
    pcsc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (file_stream.data_byte),
        .end_of_file (file_stream.end_of_file),
        .push        (push)
    );

    // Result queue between the parser and the output channel.
    pcsc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (record_stream.valid),
        .out_ready (record_stream.ready),
        .out_rec   (head_rec)
    );

    // Output payload fields.
    assign record_stream.record_kind    = head_rec.record_kind;
    assign record_stream.chunk_kind     = head_rec.chunk_kind;
    assign record_stream.text_byte      = head_rec.text_byte;
    assign record_stream.separator_mark = head_rec.separator_mark;
    assign record_stream.status         = head_rec.status;
    assign record_stream.year           = head_rec.year;
    assign record_stream.month          = head_rec.month;
    assign record_stream.day            = head_rec.day;
    assign record_stream.hour           = head_rec.hour;
    assign record_stream.minute         = head_rec.minute;
    assign record_stream.second         = head_rec.second;

endmodule
